// ===== design/itp_pkg.sv =====
// Shared types and constants for the infix-to-postfix converter.
// Used by infix_to_postfix_converter_top; depends on nothing.
package itp_pkg;

	localparam int STACK_DEPTH  = 32;
	localparam int PAYLOAD_BITS = 16;
	localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W       = $clog2(STACK_DEPTH);

	// Input token kinds
	typedef enum logic [2:0] {
		K_NUM   = 3'd0,
		K_VAR   = 3'd1,
		K_CONST = 3'd2,
		K_FUNC  = 3'd3,
		K_OPER  = 3'd4,
		K_LPAR  = 3'd5,
		K_RPAR  = 3'd6,
		K_END   = 3'd7
	} kind_t;

	// Kinds held on the stack, in two bits
	localparam logic [1:0] SK_FUNC = 2'd0;
	localparam logic [1:0] SK_OPER = 2'd1;
	localparam logic [1:0] SK_LPAR = 2'd2;

	typedef struct packed {
		logic [1:0]              skind;
		logic [2:0]              code;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]              kind;
		logic [2:0]              code;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    err;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPND,
		ST_RD,
		ST_CHK,
		ST_FNRD,
		ST_FNCHK,
		ST_PUSH,
		ST_FIN
	} state_t;

	// Operator precedence: plus/minus 1, times/divide 2, power and above 3
	function automatic logic [1:0] prec(input logic [2:0] code);
		logic [1:0] p;
		if (code <= 3'd1) begin
			p = 2'd1;
		end else if (code <= 3'd3) begin
			p = 2'd2;
		end else begin
			p = 2'd3;
		end
		return p;
	endfunction

endpackage

// ===== design/itp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; storage has no reset.
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/infix_to_postfix_converter_top.sv =====
// Infix-to-postfix converter (shunting yard), top level.
// Depends on itp_pkg and itp_ram.
//
// One token enters per input beat and the postfix tokens it releases leave as
// output beats, the final one of each token marked by last. The operator stack
// lives in a one-port-read, one-port-write RAM with a registered read port, so
// every stack inspection is a read state that gives the address followed by a
// check state that uses the data. A pop inspects its entry, an operator also
// inspects the entry that stops it, and a right paren the entry below its left
// paren. A result that finds the output register still full waits for
// out_ready. One result is held back inside the block until the next one or
// the end of its token is known, which is what lets last be set; an output
// register lets the next token be worked on while that beat waits for
// out_ready. A push onto a full stack is dropped and reported as a single beat
// with stack_error set and zero fields. The stack needs no clearing after
// reset.
module infix_to_postfix_converter_top
	import itp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              op,
	input  logic [2:0]              operator_code,
	input  logic [PAYLOAD_BITS-1:0] payload,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              token_kind,
	output logic [2:0]              out_operator_code,
	output logic [PAYLOAD_BITS-1:0] out_payload,
	output logic                    stack_error,
	output logic                    last
);

	state_t state_q, state_d;

	kind_t                   kind_q;
	logic [2:0]              code_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        cnt_q;

	res_t pend_q;
	logic pend_vld_q;
	res_t out_q;
	logic out_last_q;
	logic out_vld_q;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	entry_t             push_e;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             top_e;

	logic cnt_zero, cnt_full, out_free, emit_ok;
	logic is_lpar, is_func, pop_op, chk_pop, chk_disc;
	logic emit_c, cnt_inc, cnt_dec, fin_move, accept;
	res_t res_c, pop_res;

	itp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(push_e),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Stack status and top-of-stack decode
	assign cnt_zero  = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CNT_W'(STACK_DEPTH));
	assign ram_waddr = cnt_q[ADDR_W-1:0];
	assign ram_raddr = ADDR_W'(cnt_q - CNT_W'(1));
	assign top_e     = entry_t'(ram_rdata);
	assign is_lpar   = (top_e.skind == SK_LPAR);
	assign is_func   = (top_e.skind == SK_FUNC);
	assign pop_op    = (top_e.skind == SK_OPER) && (prec(code_q) <= prec(top_e.code));
	assign chk_pop   = (kind_q == K_OPER) ? pop_op : !is_lpar;
	assign chk_disc  = (kind_q != K_OPER) && is_lpar;

	// A new result may be taken when the held one can move to the output
	assign out_free = !out_vld_q || out_ready;
	assign emit_ok  = !pend_vld_q || out_free;
	assign accept   = in_valid && in_ready;

	// Entry for a push of the latched token
	always_comb begin
		push_e.payload = pay_q;
		push_e.code    = 3'd0;
		case (kind_q)
			K_OPER: begin
				push_e.skind = SK_OPER;
				push_e.code  = code_q;
			end
			K_LPAR:  push_e.skind = SK_LPAR;
			default: push_e.skind = SK_FUNC;
		endcase
	end

	// Result for a popped entry
	always_comb begin
		pop_res.kind    = (top_e.skind == SK_OPER) ? K_OPER : K_FUNC;
		pop_res.code    = (top_e.skind == SK_OPER) ? top_e.code : 3'd0;
		pop_res.payload = top_e.payload;
		pop_res.err     = 1'b0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (kind_t'(op))
						K_NUM, K_VAR, K_CONST: state_d = ST_OPND;
						K_FUNC, K_LPAR:        state_d = ST_PUSH;
						default:               state_d = ST_RD;
					endcase
				end
			end
			ST_OPND: begin
				if (emit_ok) begin
					state_d = ST_FIN;
				end
			end
			ST_RD: begin
				if (cnt_zero) begin
					state_d = (kind_q == K_OPER) ? ST_PUSH : ST_FIN;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (chk_pop) begin
					if (emit_ok) begin
						state_d = ST_RD;
					end
				end else if (chk_disc) begin
					state_d = (kind_q == K_RPAR) ? ST_FNRD : ST_RD;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_FNRD: begin
				state_d = cnt_zero ? ST_FIN : ST_FNCHK;
			end
			ST_FNCHK: begin
				if (!is_func || emit_ok) begin
					state_d = ST_FIN;
				end
			end
			ST_PUSH: begin
				if (!cnt_full || emit_ok) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!pend_vld_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		emit_c   = 1'b0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		fin_move = 1'b0;
		res_c    = pop_res;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_OPND: begin
				emit_c        = emit_ok;
				res_c.kind    = kind_q;
				res_c.code    = 3'd0;
				res_c.payload = pay_q;
				res_c.err     = 1'b0;
			end
			ST_RD:   ram_re = !cnt_zero;
			ST_CHK: begin
				emit_c  = chk_pop && emit_ok;
				cnt_dec = (chk_pop && emit_ok) || chk_disc;
			end
			ST_FNRD: ram_re = !cnt_zero;
			ST_FNCHK: begin
				emit_c  = is_func && emit_ok;
				cnt_dec = is_func && emit_ok;
			end
			ST_PUSH: begin
				ram_we        = !cnt_full;
				cnt_inc       = !cnt_full;
				emit_c        = cnt_full && emit_ok;
				res_c.kind    = 3'd0;
				res_c.code    = 3'd0;
				res_c.payload = '0;
				res_c.err     = 1'b1;
			end
			ST_FIN:  fin_move = pend_vld_q && out_free;
			default: ;
		endcase
	end

	// Sequencer state, latched token and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(op);
			code_q <= operator_code;
			pay_q  <= payload;
		end
	end

	// Hold back one result until its successor or the end of the token is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (emit_c) begin
			pend_vld_q <= 1'b1;
		end else if (fin_move) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_c) begin
			pend_q <= res_c;
		end
	end

	// Output register: load the held result, drop it once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((emit_c && pend_vld_q) || fin_move) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((emit_c && pend_vld_q) || fin_move) begin
			out_q      <= pend_q;
			out_last_q <= fin_move;
		end
	end

	assign out_valid         = out_vld_q;
	assign token_kind        = out_q.kind;
	assign out_operator_code = out_q.code;
	assign out_payload       = out_q.payload;
	assign stack_error       = out_q.err;
	assign last              = out_last_q;

endmodule
